// File: rtl/serial_frame_word_parser_macros.svh
// Assertion helpers included by the top-level parser file.
`ifndef SERIAL_FRAME_WORD_PARSER_MACROS_SVH
`define SERIAL_FRAME_WORD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFWP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define SFWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/sfwp_pkg.sv
package sfwp_pkg;

	localparam int NUM_MOTORS = 4;
	localparam int MOTOR_IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

	localparam logic [7:0] START_BYTE = 8'h2A;
	localparam logic [7:0] END_BYTE   = 8'h23;

	localparam logic [15:0] PATTERN_W0 = 16'h0031;
	localparam logic [15:0] PATTERN_W1 = 16'h0032;
	localparam logic [15:0] PATTERN_W2 = 16'h0033;
	localparam logic [15:0] PATTERN_W3 = 16'h0034;

	// Frame position codes: idle, first data byte, last data byte, closing byte.
	localparam logic [3:0] POS_IDLE       = 4'd0;
	localparam logic [3:0] POS_FIRST_DATA = 4'd1;
	localparam logic [3:0] POS_LAST_DATA  = 4'd8;
	localparam logic [3:0] POS_CLOSE      = 4'd9;

	typedef struct packed {
		logic             done;
		logic             pat;
		logic [3:0][15:0] words;
	} pub_t;

endpackage

// File: rtl/sfwp_frame_parser.sv
module sfwp_frame_parser
	import sfwp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output pub_t       pub
);

	logic [3:0] pos_q;
	logic [3:0] pos_d;
	logic [7:0] bytes_q [8];
	logic       wr_en;
	logic [2:0] wr_addr;

	always_comb begin
		pos_d     = pos_q;
		wr_en     = 1'b0;
		wr_addr   = 3'(pos_q - 4'd1);
		pub.done  = 1'b0;
		pub.pat   = 1'b0;
		pub.words = '0;
		if (pos_q == POS_IDLE) begin
			if (rx_byte == START_BYTE) begin
				pos_d = POS_FIRST_DATA;
			end
		end else if (pos_q <= POS_LAST_DATA) begin
			wr_en = 1'b1;
			pos_d = pos_q + 4'd1;
		end else begin
			// The closing byte, or an unreachable position, always returns to idle.
			if (pos_q == POS_CLOSE && rx_byte == END_BYTE) begin
				pub.done = 1'b1;
				for (int k = 0; k < 4; k++) begin
					pub.words[k] = {bytes_q[2 * k], bytes_q[2 * k + 1]};
				end
				pub.pat = (pub.words[0] == PATTERN_W0) && (pub.words[1] == PATTERN_W1) &&
					(pub.words[2] == PATTERN_W2) && (pub.words[3] == PATTERN_W3);
			end
			pos_d = POS_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (step) begin
			pos_q <= pos_d;
		end
	end

	// Byte slots, high byte of each word at the even slot.
	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			bytes_q[wr_addr] <= rx_byte;
		end
	end

endmodule

// File: rtl/sfwp_restart_ctr.sv
module sfwp_restart_ctr
	import sfwp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  pub_t       pub,
	input  logic [1:0] ask_index,
	output logic [7:0] restart_total
);

	logic [7:0]             run_q;
	logic [7:0]             run_inc;
	logic [7:0]             counts_q [NUM_MOTORS];
	logic                   motor_ok;
	logic [MOTOR_IDX_W-1:0] motor;
	logic                   bump;
	logic [7:0]             count_cur;

	assign run_inc  = run_q + 8'd1;
	assign motor_ok = 32'(ask_index) < NUM_MOTORS;
	assign motor    = MOTOR_IDX_W'(ask_index);
	assign bump     = pub.done && pub.pat && (run_inc == 8'd1) && motor_ok;

	always_comb begin
		count_cur = 8'd0;
		if (motor_ok) begin
			count_cur = counts_q[motor];
		end
		restart_total = bump ? count_cur + 8'd1 : count_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 8'd0;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				counts_q[m] <= 8'd0;
			end
		end else if (step) begin
			if (pub.done) begin
				run_q <= pub.pat ? run_inc : 8'd0;
			end
			if (bump) begin
				counts_q[motor] <= count_cur + 8'd1;
			end
		end
	end

endmodule

// File: rtl/serial_frame_word_parser.sv
// Serial frame word parser. Each input word carries one received byte and a
// motor index; each produces exactly one output word. A frame is '*', eight
// data bytes forming four big-endian 16-bit words, and a closing '#'. On the
// closing '#' the words are published with tlast set, and tuser flags the
// pattern '1','2','3','4', which steps a run counter and, when the run
// reaches one, bumps the restart count of the indexed motor. Every output
// reports that motor's restart count after its byte. Each byte passes
// through an input register and then a result register; one word is
// accepted every cycle as long as the output side keeps taking results.
`include "serial_frame_word_parser_macros.svh"

module serial_frame_word_parser
	import sfwp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte[7:0], ask_index[9:8], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // word_a, word_b, word_c, word_d, restart_total
	output logic        m_tlast,   // frame_done
	output logic        m_tuser    // pattern_seen
);

	logic       valid_s1;
	logic [7:0] rx_s1;
	logic [1:0] idx_s1;
	logic       adv_out;
	logic       step;
	pub_t       pub;
	logic [7:0] restart_total;

	assign adv_out  = !m_tvalid || m_tready;
	assign step     = valid_s1 && adv_out;
	assign s_tready = !valid_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_s1  <= s_tdata[7:0];
			idx_s1 <= s_tdata[9:8];
		end
	end

	sfwp_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_s1),
		.pub     (pub)
	);

	sfwp_restart_ctr u_restart (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.pub           (pub),
		.ask_index     (idx_s1),
		.restart_total (restart_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_out) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata <= {restart_total, pub.words[3], pub.words[2], pub.words[1], pub.words[0]};
			m_tlast <= pub.done;
			m_tuser <= pub.pat;
		end
	end

	`SFWP_ASSERT_NOW(a_pat_needs_done, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`SFWP_ASSERT_NOW(a_words_zero_idle, clk, arst_n, m_tvalid && !m_tlast, m_tdata[63:0] == 64'd0)
	`SFWP_ASSERT_NEXT(a_step_fills_out, clk, arst_n, step, m_tvalid)

endmodule

// File: tb/serial_frame_word_parser_tb.sv
`timescale 1ns / 100ps

module serial_frame_word_parser_tb;
	import sfwp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD_CYCLES = 120;

	typedef struct packed {
		logic             done;
		logic [3:0][15:0] words;
		logic             pat;
		logic signed [7:0] total;
	} parse_result_t;

	typedef struct {
		logic [7:0]    rx;
		logic [1:0]    motor;
		bit            typed;
		parse_result_t result;
	} stim_row_t;

	localparam parse_result_t QUIET_RESULT = '0;
	localparam parse_result_t PATTERN_RESULT =
		'{1'b1, {PATTERN_W3, PATTERN_W2, PATTERN_W1, PATTERN_W0}, 1'b1, 8'sd1};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // rx_byte[7:0], ask_index[9:8], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // word_a, word_b, word_c, word_d, restart_total
	logic        m_tlast;   // frame_done
	logic        m_tuser;   // pattern_seen

	// Parser state as the testbench expects it.
	logic [3:0]  frame_pos;
	logic [15:0] frame_words [4];
	logic [7:0]  pattern_run;
	logic [7:0]  restart_counts [NUM_MOTORS];

	parse_result_t expected_results [$];
	int          mismatches;
	int          frame_bytes;
	int          sender_idle_pct;
	int          rx_idle_pct;
	bit          long_hold_req;
	int          hold_left;
	int          cycle_count;
	stim_row_t   directed_rows [21];

	serial_frame_word_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic parse_result_t step_parser(logic [7:0] rx, logic [1:0] motor);
		parse_result_t r;
		int slot;
		r = '0;
		if (frame_pos == POS_IDLE) begin
			if (rx == START_BYTE)
				frame_pos = POS_FIRST_DATA;
		end else if (frame_pos <= POS_LAST_DATA) begin
			slot = (int'(frame_pos) - 1) / 2;
			// Odd positions carry the high byte of a word.
			if (frame_pos[0])
				frame_words[slot] = {rx, 8'h00};
			else
				frame_words[slot][7:0] = rx;
			frame_pos = frame_pos + 4'd1;
		end else begin
			if (frame_pos == POS_CLOSE && rx == END_BYTE) begin
				r.done = 1'b1;
				r.words = {frame_words[3], frame_words[2], frame_words[1], frame_words[0]};
				r.pat = frame_words[0] == PATTERN_W0 && frame_words[1] == PATTERN_W1 &&
					frame_words[2] == PATTERN_W2 && frame_words[3] == PATTERN_W3;
				if (r.pat) begin
					pattern_run = pattern_run + 8'd1;
					if (pattern_run == 8'd1 && int'(motor) < NUM_MOTORS)
						restart_counts[motor] = restart_counts[motor] + 8'd1;
				end else begin
					pattern_run = '0;
				end
			end
			frame_pos = POS_IDLE;
		end
		r.total = (int'(motor) < NUM_MOTORS) ? restart_counts[motor] : 8'sd0;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] rx, input logic [1:0] motor,
			input bit typed = 1'b0, input parse_result_t typed_result = '0);
		parse_result_t predicted;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, motor, rx};
		do @(posedge clk); while (!s_tready);
		predicted = step_parser(rx, motor);
		expected_results.push_back(typed ? typed_result : predicted);
	endtask

	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [1:0] pick_motor(int motor);
		return (motor < 0) ? 2'($urandom_range(0, 3)) : 2'(motor);
	endfunction

	// A negative motor picks a fresh index for every byte.
	task automatic send_frame(input bit pattern, input bit good_close, input int motor);
		logic [7:0] data [8];
		logic [7:0] closer;
		int pick;
		data = '{8'h00, PATTERN_W0[7:0], 8'h00, PATTERN_W1[7:0],
			8'h00, PATTERN_W2[7:0], 8'h00, PATTERN_W3[7:0]};
		if (!pattern) begin
			// Near misses spoil exactly one byte of the pattern; otherwise all data bytes are random.
			if ($urandom_range(0, 99) < 30) begin
				pick = $urandom_range(0, 7);
				data[pick] = data[pick] ^ 8'($urandom_range(1, 255));
			end else begin
				foreach (data[i])
					data[i] = pick_data_byte();
			end
		end
		closer = good_close ? END_BYTE : 8'($urandom_range(0, 255));
		send_byte(START_BYTE, pick_motor(motor));
		foreach (data[i])
			send_byte(data[i], pick_motor(motor));
		send_byte(closer, pick_motor(motor));
		frame_bytes += 10;
	endtask

	task automatic random_traffic(input int n_items);
		int target;
		int kind;
		int n;
		target = frame_bytes + n_items;
		while (frame_bytes < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				// Line noise between frames.
				n = $urandom_range(1, 3);
				repeat (n)
					send_byte(pick_data_byte(), pick_motor(-1));
				frame_bytes += n;
			end else if (kind < 20) begin
				// A frame cut short; whatever follows takes its remaining positions.
				n = $urandom_range(1, 8);
				send_byte(START_BYTE, pick_motor(-1));
				repeat (n)
					send_byte(pick_data_byte(), pick_motor(-1));
				frame_bytes += n + 1;
			end else begin
				send_frame($urandom_range(0, 99) < 45, $urandom_range(0, 99) < 88, -1);
			end
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] exp,
			input logic [15:0] got);
		if (exp !== got) begin
			$error("%s: expected %0h, got %0h", name, exp, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		parse_result_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				exp = expected_results.pop_front();
				check_field("frame_done", 16'(exp.done), 16'(m_tlast));
				check_field("word_a", exp.words[0], m_tdata[15:0]);
				check_field("word_b", exp.words[1], m_tdata[31:16]);
				check_field("word_c", exp.words[2], m_tdata[47:32]);
				check_field("word_d", exp.words[3], m_tdata[63:48]);
				check_field("pattern_seen", 16'(exp.pat), 16'(m_tuser));
				check_field("restart_total", 16'(exp.total[7:0]), 16'(m_tdata[71:64]));
			end
		end
	end

	// Receiver side: random back-pressure, plus one long hold on request.
	initial begin
		m_tready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		mismatches = 0;
		frame_bytes = 0;
		long_hold_req = 1'b0;
		sender_idle_pct = 38;
		rx_idle_pct = 78;
		frame_pos = POS_IDLE;
		pattern_run = '0;
		foreach (frame_words[i])
			frame_words[i] = '0;
		foreach (restart_counts[i])
			restart_counts[i] = '0;

		// The first frame has extreme data bytes and a bad closing byte, then a
		// stray '#' while idle, then a pattern frame that bumps motor 2.
		directed_rows = '{
			'{START_BYTE, 2'd0, 1'b1, QUIET_RESULT},
			'{8'hFF, 2'd3, 1'b0, QUIET_RESULT},
			'{8'hFF, 2'd0, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd3, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd1, 1'b0, QUIET_RESULT},
			'{8'hFF, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd0, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd3, 1'b0, QUIET_RESULT},
			'{8'hFF, 2'd0, 1'b0, QUIET_RESULT},
			'{8'hFF, 2'd3, 1'b1, QUIET_RESULT},
			'{END_BYTE, 2'd1, 1'b0, QUIET_RESULT},
			'{START_BYTE, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h31, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h32, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h33, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h00, 2'd2, 1'b0, QUIET_RESULT},
			'{8'h34, 2'd2, 1'b0, QUIET_RESULT},
			'{END_BYTE, 2'd2, 1'b1, PATTERN_RESULT}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].motor,
				directed_rows[i].typed, directed_rows[i].result);

		random_traffic(330);
		// The sender stops until the output side has caught up completely.
		wait_for_results();

		sender_idle_pct = 78;
		rx_idle_pct = 38;
		random_traffic(330);

		sender_idle_pct = 0;
		rx_idle_pct = 0;
		long_hold_req = 1'b1;
		random_traffic(340);

		// Clear the run, then pattern frames in a row; only the first of them
		// bumps motor 3.
		send_frame(1'b0, 1'b1, 0);
		repeat (12)
			send_frame(1'b1, 1'b1, 3);

		// Alternate pattern and plain frames so every pattern frame after the first bumps motor 1.
		repeat (8) begin
			send_frame(1'b1, 1'b1, 1);
			send_frame(1'b0, 1'b1, -1);
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
